/* rtl/connection_admission_limiter_top_assert.svh */
// Assertion macros shared by the admission limiter RTL.
// Needs a signal named clock and a signal named reset in the including module.
`ifndef CONNECTION_ADMISSION_LIMITER_TOP_ASSERT_SVH
`define CONNECTION_ADMISSION_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CAL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cal_pkg.sv */
// Shared types, codes and sizes for the connection admission limiter.
// No dependencies; imported by cal_csr, cal_seq and the top level.
package cal_pkg;

   localparam int SOURCE_SLOTS = 64;
   localparam int SLOT_BITS    = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SOURCE_SLOTS - 1);

   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 64;
   localparam int ENTRY_BITS = 2 * KEY_BITS + COUNT_BITS;

   localparam logic [31:0] V4_MAP_PREFIX = 32'h0000_FFFF;

   localparam logic OP_ADMIT   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] FAM_IPV4 = 2'd0;
   localparam logic [1:0] FAM_IPV6 = 2'd1;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic REG_MAX_TOTAL      = 1'b0;
   localparam logic REG_MAX_PER_SOURCE = 1'b1;

   localparam logic [COUNT_BITS-1:0] RESET_MAX_TOTAL      = 16'd1024;
   localparam logic [COUNT_BITS-1:0] RESET_MAX_PER_SOURCE = 16'd64;

   typedef enum logic [2:0] {
      STATUS_ADMITTED        = 3'd0,
      STATUS_TOTAL_LIMIT     = 3'd1,
      STATUS_SOURCE_LIMIT    = 3'd2,
      STATUS_TABLE_FULL      = 3'd3,
      STATUS_RELEASED        = 3'd4,
      STATUS_RELEASE_UNKNOWN = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN,
      SEQ_DECIDE
   } seq_state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] max_total;
      logic [COUNT_BITS-1:0] max_per_source;
   } cfg_type;

endpackage

/* rtl/cal_slot_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cal_slot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cal_csr.sv */
// Limit registers behind the APB-style configuration port.
// Depends on cal_pkg.
module cal_csr
   import cal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [COUNT_BITS-1:0] max_total_ff;
   logic [COUNT_BITS-1:0] max_per_source_ff;
   logic                  wr_fire;
   logic                  reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff      <= RESET_MAX_TOTAL;
         max_per_source_ff <= RESET_MAX_PER_SOURCE;
      end else if (wr_fire) begin
         if (reg_sel == REG_MAX_TOTAL) begin
            max_total_ff <= csr_pwdata[COUNT_BITS-1:0];
         end else begin
            max_per_source_ff <= csr_pwdata[COUNT_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_MAX_PER_SOURCE) begin
         csr_prdata = {16'd0, max_per_source_ff};
      end else begin
         csr_prdata = {16'd0, max_total_ff};
      end
   end

   assign cfg.max_total      = max_total_ff;
   assign cfg.max_per_source = max_per_source_ff;

endmodule

/* rtl/cal_seq.sv */
// Sequencer: scans the slot table through one key comparator, then updates.
// Depends on cal_pkg, cal_slot_ram and the assertion macro header.
`include "connection_admission_limiter_top_assert.svh"

module cal_seq
   import cal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [1:0]            req_family,
   input  logic [KEY_BITS-1:0]   req_addr_high,
   input  logic [KEY_BITS-1:0]   req_addr_low,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [COUNT_BITS-1:0] rsp_active_total,
   output logic [COUNT_BITS-1:0] rsp_source_count
);

   seq_state_type state_ff, state_in;

   logic                    op_ff;
   logic [KEY_BITS-1:0]     key_hi_ff, key_lo_ff;
   logic [KEY_BITS-1:0]     key_hi_in, key_lo_in;
   logic [SLOT_BITS-1:0]    scan_idx_ff;
   logic                    cmp_valid_ff;
   logic [SLOT_BITS-1:0]    cmp_idx_ff;
   logic                    found_ff, free_found_ff;
   logic [SLOT_BITS-1:0]    match_idx_ff, free_idx_ff;
   logic [COUNT_BITS-1:0]   match_cnt_ff;
   logic [SOURCE_SLOTS-1:0] valid_ff;
   logic [COUNT_BITS-1:0]   total_ff;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [COUNT_BITS-1:0]   rsp_total_ff, rsp_src_ff;

   logic                    req_fire, out_free, decide_fire, scan_rd;
   logic [ENTRY_BITS-1:0]   rd_data, wr_data;
   logic [KEY_BITS-1:0]     rd_key_hi, rd_key_lo;
   logic [COUNT_BITS-1:0]   rd_cnt;
   logic                    hit, slot_free;

   status_type              dec_status;
   logic [COUNT_BITS-1:0]   dec_src, dec_total, src_cur, wr_cnt;
   logic [SLOT_BITS-1:0]    wr_slot;
   logic                    wr_en, valid_set, valid_clr;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:   if (req_valid) state_in = SEQ_SCAN;
         SEQ_SCAN:   if (scan_idx_ff == SLOT_LAST) state_in = SEQ_DRAIN;
         SEQ_DRAIN:  state_in = SEQ_DECIDE;
         SEQ_DECIDE: if (out_free) state_in = SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == SEQ_IDLE);
      scan_rd     = (state_ff == SEQ_SCAN);
      out_free    = !rsp_valid_ff || rsp_ready;
      decide_fire = (state_ff == SEQ_DECIDE) && out_free;
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // IPv4 maps to ::ffff:a.b.c.d, unknown families to the zero key
   always_comb begin
      unique case (req_family)
         FAM_IPV4: begin
            key_hi_in = '0;
            key_lo_in = {V4_MAP_PREFIX, req_addr_low[31:0]};
         end
         FAM_IPV6: begin
            key_hi_in = req_addr_high;
            key_lo_in = req_addr_low;
         end
         default: begin
            key_hi_in = '0;
            key_lo_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_operation;
         key_hi_ff <= key_hi_in;
         key_lo_ff <= key_lo_in;
      end
   end

   // ---------------- scan ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_idx_ff   <= '0;
      end else begin
         cmp_valid_ff <= scan_rd;
         cmp_idx_ff   <= scan_idx_ff;
         if (req_fire) begin
            scan_idx_ff <= '0;
         end else if (scan_rd && scan_idx_ff != SLOT_LAST) begin
            scan_idx_ff <= scan_idx_ff + SLOT_BITS'(1);
         end
      end
   end

   cal_slot_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SOURCE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (wr_data),
      .rd_en   (scan_rd),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign {rd_key_hi, rd_key_lo, rd_cnt} = rd_data;

   // the one shared comparator; stale words of free slots are masked by the valid bit
   assign slot_free = !valid_ff[cmp_idx_ff];
   assign hit = cmp_valid_ff && !slot_free &&
                (rd_key_hi == key_hi_ff) && (rd_key_lo == key_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (req_fire) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (hit && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (cmp_valid_ff && slot_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit && !found_ff) begin
         match_idx_ff <= cmp_idx_ff;
         match_cnt_ff <= rd_cnt;
      end
      if (cmp_valid_ff && slot_free && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   // ---------------- decision ----------------
   assign src_cur = found_ff ? match_cnt_ff : '0;

   always_comb begin
      dec_status = STATUS_ADMITTED;
      dec_src    = src_cur;
      dec_total  = total_ff;
      wr_slot    = found_ff ? match_idx_ff : free_idx_ff;
      wr_cnt     = match_cnt_ff;
      wr_en      = 1'b0;
      valid_set  = 1'b0;
      valid_clr  = 1'b0;
      if (op_ff == OP_ADMIT) begin
         priority if (total_ff >= cfg.max_total) begin
            dec_status = STATUS_TOTAL_LIMIT;
         end else if (src_cur >= cfg.max_per_source) begin
            dec_status = STATUS_SOURCE_LIMIT;
         end else if (!found_ff && !free_found_ff) begin
            dec_status = STATUS_TABLE_FULL;
            dec_src    = '0;
         end else begin
            // neither add can wrap: both sit below a 16-bit limit
            wr_cnt     = src_cur + COUNT_BITS'(1);
            dec_src    = wr_cnt;
            dec_total  = total_ff + COUNT_BITS'(1);
            wr_en      = decide_fire;
            valid_set  = decide_fire;
         end
      end else begin
         if (found_ff) begin
            dec_status = STATUS_RELEASED;
            if (match_cnt_ff != '0) begin
               wr_cnt = match_cnt_ff - COUNT_BITS'(1);
            end
            dec_src   = wr_cnt;
            wr_en     = decide_fire;
            valid_clr = decide_fire && (wr_cnt == '0);
         end else begin
            dec_status = STATUS_RELEASE_UNKNOWN;
            dec_src    = '0;
         end
         if (total_ff != '0) begin
            dec_total = total_ff - COUNT_BITS'(1);
         end
      end
   end

   assign wr_data = {key_hi_ff, key_lo_ff, wr_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else if (decide_fire) begin
         total_ff <= dec_total;
         if (valid_set) begin
            valid_ff[wr_slot] <= 1'b1;
         end else if (valid_clr) begin
            valid_ff[wr_slot] <= 1'b0;
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decide_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_fire) begin
         rsp_status_ff <= dec_status;
         rsp_total_ff  <= dec_total;
         rsp_src_ff    <= dec_src;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_active_total = rsp_total_ff;
   assign rsp_source_count = rsp_src_ff;

   // ---------------- checks ----------------
   `CAL_ASSERT_NOW(a_busy_not_ready, state_ff != SEQ_IDLE, !req_ready, "ready while busy")
   `CAL_ASSERT_NEXT(a_scan_starts_at_zero, req_fire, (state_ff == SEQ_SCAN) && (scan_idx_ff == '0), "scan did not restart")
   `CAL_ASSERT_NEXT(a_admit_bumps_total, decide_fire && (dec_status == STATUS_ADMITTED), total_ff == $past(total_ff) + COUNT_BITS'(1), "admit did not raise total")
   `CAL_ASSERT_NEXT(a_unknown_keeps_slots, decide_fire && (dec_status == STATUS_RELEASE_UNKNOWN), valid_ff == $past(valid_ff), "unknown release touched table")

endmodule

/* rtl/connection_admission_limiter_top.sv */
// Requests are taken only in idle; the states then run scan, drain and decide, and
// decide waits for a free result register. The event rate is set by the slot-table
// scan through a single RAM read port and one 128-bit key comparator.
// Reset (synchronous, active high): all slots free, total zero, limits 1024 and 64;
// no clearing pass, the per-slot valid flops clear at once.
// Top level: joins the limit registers and the scanning sequencer; needs cal_pkg.
module connection_admission_limiter_top
   import cal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [1:0]               req_family,
   input  logic [KEY_BITS-1:0]      req_addr_high,
   input  logic [KEY_BITS-1:0]      req_addr_low,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [COUNT_BITS-1:0]    rsp_active_total,
   output logic [COUNT_BITS-1:0]    rsp_source_count,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;

   cal_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cal_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_family       (req_family),
      .req_addr_high    (req_addr_high),
      .req_addr_low     (req_addr_low),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_active_total (rsp_active_total),
      .rsp_source_count (rsp_source_count)
   );

endmodule
